// ----- design/full_linear_convolution_top_macros.svh -----
// assertion macros used by the convolution top level
`ifndef FULL_LINEAR_CONVOLUTION_TOP_MACROS_SVH
`define FULL_LINEAR_CONVOLUTION_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("convolution assertion failed");

// consequent checked in the cycle after the antecedent
`define FLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("convolution assertion failed");

`endif

// ----- design/flc_pkg.sv -----
// types and constants of the full linear convolution block
`default_nettype none
package flc_pkg;

  localparam int KernelTapsDefault = 64;
  localparam int SampleBits        = 16;
  localparam int ProdBits          = 2 * SampleBits;
  localparam int SumBits           = 38;

  localparam logic OpTap    = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic                         operation;
    logic signed [SampleBits-1:0] sample_value;
    logic                         is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SumBits-1:0] sum_value;
    logic                      last_of_run;
    logic                      no_kernel;
  } out_item_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic tap_we;
    logic shift_en;
    logic clear;
  } flc_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

// ----- design/flc_cell.sv -----
// one tap cell: kernel tap, history stage, product and partial sum
`default_nettype none
module flc_cell #(
  parameter int Index = 0,
  parameter int LenW  = 7
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire flc_pkg::flc_ctrl_t                    ctrl_i,
  input  wire logic [LenW-1:0]                       tap_idx_i,
  input  wire logic [LenW-1:0]                       len_i,
  input  wire logic signed [flc_pkg::SampleBits-1:0] tap_value_i,
  input  wire logic signed [flc_pkg::SampleBits-1:0] hist_i,
  input  wire logic signed [flc_pkg::SumBits-1:0]    acc_i,
  output logic signed [flc_pkg::SampleBits-1:0]      hist_o,
  output logic signed [flc_pkg::SumBits-1:0]         acc_o
);
  import flc_pkg::*;

  logic signed [SampleBits-1:0] tap_q;
  logic signed [SampleBits-1:0] hist_q;
  logic signed [ProdBits-1:0]   full_prod;
  logic signed [SumBits-1:0]    prod_d, prod_q;
  logic signed [SumBits-1:0]    acc_q;
  logic                         active;

  // cell takes part only while its index lies inside the kernel
  assign active    = (LenW'(Index) < len_i);
  assign full_prod = tap_q * hist_q;
  assign prod_d    = active ? SumBits'(full_prod) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (ctrl_i.clear) begin
      hist_q <= '0;
    end else if (ctrl_i.shift_en) begin
      hist_q <= hist_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_we && (tap_idx_i == LenW'(Index))) begin
      tap_q <= tap_value_i;
    end
    prod_q <= prod_d;
    acc_q  <= acc_i + prod_q;
  end

  assign hist_o = hist_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

// ----- design/flc_chain.sv -----
// row of tap cells with the delay line and the partial sum chain
`default_nettype none
module flc_chain #(
  parameter int KernelTaps = flc_pkg::KernelTapsDefault,
  parameter int LenW       = $clog2(KernelTaps + 1)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire flc_pkg::flc_ctrl_t                    ctrl_i,
  input  wire logic [LenW-1:0]                       tap_idx_i,
  input  wire logic [LenW-1:0]                       len_i,
  input  wire logic signed [flc_pkg::SampleBits-1:0] tap_value_i,
  input  wire logic signed [flc_pkg::SampleBits-1:0] sample_i,
  output logic signed [flc_pkg::SumBits-1:0]         sum_o
);
  import flc_pkg::*;

  logic signed [SampleBits-1:0] hist_in  [KernelTaps];
  logic signed [SampleBits-1:0] hist_out [KernelTaps];
  logic signed [SumBits-1:0]    acc_in   [KernelTaps];
  logic signed [SumBits-1:0]    acc_out  [KernelTaps];

  for (genvar k = 0; k < KernelTaps; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign hist_in[k] = sample_i;
      assign acc_in[k]  = '0;
    end else begin : g_body
      assign hist_in[k] = hist_out[k-1];
      assign acc_in[k]  = acc_out[k-1];
    end

    flc_cell #(
      .Index (k),
      .LenW  (LenW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .tap_idx_i   (tap_idx_i),
      .len_i       (len_i),
      .tap_value_i (tap_value_i),
      .hist_i      (hist_in[k]),
      .acc_i       (acc_in[k]),
      .hist_o      (hist_out[k]),
      .acc_o       (acc_out[k])
    );
  end

  assign sum_o = acc_out[KernelTaps-1];

endmodule
`default_nettype wire

// ----- design/full_linear_convolution_top.sv -----
// top level of the full linear convolution block: sequencer, cell row, output register
// a sample's sum passes through the cell row's product and partial sum registers, then the output register
// taps are taken one per cycle while the sequencer is idle; a sample is taken only once the
// previous sample's sums, flushed tail included, have been loaded into the output register
// a sample without a closed kernel skips the sum chain; its flagged result is registered from emit
// reset clears the history, kernel length and closed flag; kernel taps stay undefined
`default_nettype none
`include "full_linear_convolution_top_macros.svh"
module full_linear_convolution_top #(
  parameter int KernelTaps = flc_pkg::KernelTapsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire flc_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output flc_pkg::out_item_t      out_data_o
);
  import flc_pkg::*;

  localparam int LenW = $clog2(KernelTaps + 1);

  state_e           state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  rem_q, rem_d;     // tail sums still to come
  logic [LenW-1:0]  cnt_q, cnt_d;     // settle counter of the sum chain
  logic             closed_q, closed_d;
  logic             last_q, last_d;
  logic             nk_q, nk_d;
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             out_load;
  logic             in_fire;
  flc_ctrl_t        ctrl;
  logic [LenW-1:0]  tap_idx;
  logic signed [SampleBits-1:0] chain_x;
  logic signed [SumBits-1:0]    chain_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // output register frees up when empty or being drained
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // a tap after a closed kernel restarts the kernel at slot zero
  assign tap_idx = closed_q ? '0 : len_q;
  // new samples enter only from idle, the flushed tail shifts in zeros
  assign chain_x = (state_q == ST_IDLE) ? in_data_i.sample_value : '0;

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    closed_d = closed_q;
    last_d   = last_q;
    nk_d     = nk_q;
    ctrl     = '0;
    out_d    = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.operation == OpTap) begin
            if (closed_q) begin
              closed_d   = 1'b0;
              ctrl.clear = 1'b1;
            end
            // taps beyond the row are dropped, length saturates
            if (tap_idx < LenW'(KernelTaps)) begin
              ctrl.tap_we = 1'b1;
              len_d       = tap_idx + LenW'(1);
            end else begin
              len_d = tap_idx;
            end
            if (in_data_i.is_last) begin
              closed_d = 1'b1;
            end
          end else if (!closed_q || (len_q == '0)) begin
            // no kernel: flagged zero result, state untouched
            nk_d    = 1'b1;
            last_d  = 1'b0;
            rem_d   = '0;
            state_d = ST_EMIT;
          end else begin
            ctrl.shift_en = 1'b1;
            nk_d    = 1'b0;
            last_d  = in_data_i.is_last;
            rem_d   = in_data_i.is_last ? (len_q - LenW'(1)) : '0;
            cnt_d   = '0;
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        // product stage plus one adder per cell before the chain end settles
        cnt_d = cnt_q + LenW'(1);
        if (cnt_q == LenW'(KernelTaps)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_d.sum_value   = nk_q ? '0 : chain_sum;
          out_d.last_of_run = last_q && (rem_q == '0) && !nk_q;
          out_d.no_kernel   = nk_q;
          if (rem_q != '0) begin
            ctrl.shift_en = 1'b1;
            rem_d   = rem_q - LenW'(1);
            cnt_d   = '0;
            state_d = ST_WAIT;
          end else begin
            // end of the run wipes the history
            if (last_q && !nk_q) begin
              ctrl.clear = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      closed_q    <= 1'b0;
      last_q      <= 1'b0;
      nk_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
      last_q   <= last_d;
      nk_q     <= nk_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  flc_chain #(
    .KernelTaps (KernelTaps),
    .LenW       (LenW)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .tap_idx_i   (tap_idx),
    .len_i       (len_q),
    .tap_value_i (in_data_i.sample_value),
    .sample_i    (chain_x),
    .sum_o       (chain_sum)
  );

  // tail sums only follow a final sample
  `FLC_ASSERT_SAME(a_tail_needs_last, rem_q != '0, last_q && !nk_q)
  // kernel length never exceeds the row
  `FLC_ASSERT_SAME(a_len_bounded, 1'b1, len_q <= LenW'(KernelTaps))
  // final sum of a run returns the sequencer to idle
  `FLC_ASSERT_NEXT(a_run_end_idle, out_load && out_d.last_of_run, state_q == ST_IDLE)
  // a blocked result keeps the sequencer waiting on the output register
  `FLC_ASSERT_NEXT(a_emit_holds, (state_q == ST_EMIT) && out_valid_q && !out_ready_i,
                   state_q == ST_EMIT)

endmodule
`default_nettype wire

// ----- dv/tb_full_linear_convolution_top.sv -----
// self-checking testbench for the full linear convolution block with random stalls on both sides
`default_nettype none
module tb_full_linear_convolution_top;
  timeunit 1ns;
  timeprecision 1ps;

  import flc_pkg::*;

  localparam int KernelTaps = KernelTapsDefault;
  // rough input item count at which the random part stops
  localparam int ItemGoal   = 460;
  // receiver stops taking sums for a long stretch after this many sums
  localparam int HoldAfter  = 40;
  localparam int HoldCycles = 800;
  // cycles with no transfer on either side before the run is called hung;
  // the worst legal quiet stretch is the long hold-off plus one sum latency
  localparam int StuckLimit = 4000;
  // mismatch lines printed before the report goes quiet (counting goes on)
  localparam int PrintCap   = 50;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [SumBits-1:0]    sum_t;

  // one input item together with the idle cycles the sender waits after it
  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } paced_item_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block ports, known from time zero
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;

  // sender side
  paced_item_t pending_items[$];
  paced_item_t next_slot;
  int unsigned tx_gap     = 0;
  bit          tx_idle_on = 1'b1;
  int          n_items    = 0;

  // receiver side
  int unsigned rx_wait    = 0;
  int unsigned rx_draw    = 0;
  bit          rx_idle_on = 1'b1;

  // predicted sums waiting for the block, oldest first
  out_item_t expected_sums[$];

  // shadow of the block state, history empty out of reset
  sample_t     kernel_mem[KernelTaps];
  sample_t     history[KernelTaps] = '{default: '0};
  int unsigned kernel_len  = 0;
  bit          kernel_done = 1'b0;

  // bookkeeping
  int n_errors    = 0;
  int n_results   = 0;
  int n_taps      = 0;
  int n_samples   = 0;
  int n_no_kernel = 0;
  int max_kernel  = 0;
  int stuck_cycles = 0;

  full_linear_convolution_top #(
    .KernelTaps(KernelTaps)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // newest sample goes to slot 0, the oldest drops off the far end
  function automatic void shift_history(input sample_t x);
    for (int i = KernelTaps - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = x;
  endfunction

  // exact sum of products over the taps of the current kernel
  function automatic sum_t fir_sum();
    longint acc;
    acc = 0;
    for (int unsigned k = 0; k < kernel_len && k < KernelTaps; k++) begin
      acc += longint'(kernel_mem[k]) * longint'(history[k]);
    end
    return acc[SumBits-1:0];
  endfunction

  // advance the shadow state by one accepted item and queue the sums it causes
  function automatic void convolve_item(input in_item_t it);
    out_item_t res;
    res = '0;
    if (it.operation == OpTap) begin
      n_taps++;
      // a tap after a closed kernel starts a fresh kernel with empty history
      if (kernel_done) begin
        kernel_done = 1'b0;
        kernel_len  = 0;
        history     = '{default: '0};
      end
      // taps past the end of the kernel store are dropped
      if (kernel_len < KernelTaps) begin
        kernel_mem[kernel_len] = it.sample_value;
        kernel_len++;
      end
      if (it.is_last) kernel_done = 1'b1;
      if (kernel_len > max_kernel) max_kernel = kernel_len;
      return;
    end
    n_samples++;
    // sample with no closed kernel: flagged zero sum, state untouched
    if (!kernel_done || kernel_len == 0) begin
      res.no_kernel = 1'b1;
      n_no_kernel++;
      expected_sums.push_back(res);
      return;
    end
    shift_history(it.sample_value);
    res.sum_value   = fir_sum();
    res.last_of_run = it.is_last && kernel_len == 1;
    expected_sums.push_back(res);
    // last sample: flush the tail as if zeros followed, then forget the signal
    if (it.is_last) begin
      for (int unsigned t = 1; t < kernel_len; t++) begin
        shift_history('0);
        res.sum_value   = fir_sum();
        res.last_of_run = (t == kernel_len - 1);
        expected_sums.push_back(res);
      end
      history = '{default: '0};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PrintCap) $display("mismatch: %s", msg);
  endtask

  task automatic check_sum(input out_item_t got);
    out_item_t want;
    n_results++;
    if (expected_sums.size() == 0) begin
      flag_mismatch($sformatf("sum %0d arrived with nothing expected", n_results));
      return;
    end
    want = expected_sums.pop_front();
    if (got.sum_value !== want.sum_value)
      flag_mismatch($sformatf("sum %0d: sum_value %0d, expected %0d",
                              n_results, got.sum_value, want.sum_value));
    if (got.last_of_run !== want.last_of_run)
      flag_mismatch($sformatf("sum %0d: last_of_run %b, expected %b",
                              n_results, got.last_of_run, want.last_of_run));
    if (got.no_kernel !== want.no_kernel)
      flag_mismatch($sformatf("sum %0d: no_kernel %b, expected %b",
                              n_results, got.no_kernel, want.no_kernel));
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item per transfer, fed from the pending queue
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      tx_gap   <= 0;
    end else begin
      // predict at the transfer itself, so the shadow sees exactly what the block took
      if (in_valid && in_ready_o) convolve_item(in_data);
      // an offered item stays put until it transfers
      if (!in_valid || in_ready_o) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (pending_items.size() != 0) begin
          next_slot = pending_items.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_slot.item;
          tx_gap   <= next_slot.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each sum transfer and paces the ready line
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        check_sum(out_data_o);
        if (n_results == HoldAfter) begin
          // long hold-off: the sender keeps offering, so the block backs up
          out_ready <= 1'b0;
          rx_wait   <= HoldCycles;
        end else begin
          // stretches of random stalls alternate with stretches of none
          if ($urandom_range(0, 23) == 0) rx_idle_on = !rx_idle_on;
          rx_draw = rx_idle_on ? $urandom_range(0, 15) : 0;
          out_ready <= (rx_draw == 0);
          rx_wait   <= rx_draw;
        end
      end else if (rx_wait != 0) begin
        out_ready <= (rx_wait == 1);
        rx_wait   <= rx_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on transfers of either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d sums still expected",
                 stuck_cycles, expected_sums.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // mostly random bits, with the corner values drawn often
  function automatic sample_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        return {1'b1, {(SampleBits-1){1'b0}}};
      end
      1: begin
        return {1'b0, {(SampleBits-1){1'b1}}};
      end
      2: begin
        return '0;
      end
      3: begin
        return '1;
      end
      default: begin
        return SampleBits'($urandom());
      end
    endcase
  endfunction

  task automatic add_item(input logic op, input sample_t value, input logic last);
    paced_item_t slot;
    slot.item.operation    = op;
    slot.item.sample_value = value;
    slot.item.is_last      = last;
    if ($urandom_range(0, 19) == 0) tx_idle_on = !tx_idle_on;
    slot.gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    pending_items.push_back(slot);
    n_items++;
  endtask

  task automatic add_kernel(input int len, input bit close);
    for (int i = 0; i < len; i++) add_item(OpTap, pick_value(), close && i == len - 1);
  endtask

  task automatic add_signal(input int len, input bit close);
    for (int i = 0; i < len; i++) add_item(OpSample, pick_value(), close && i == len - 1);
  endtask

  initial begin
    int pick;
    int n_big;
    sample_t most_neg;
    most_neg = {1'b1, {(SampleBits-1){1'b0}}};
    n_big    = 0;

    // directed part
    // samples before any kernel exists, plain and marked last
    add_item(OpSample, 16'sh1234, 1'b0);
    add_item(OpSample, most_neg, 1'b1);
    // one-tap kernel: the last sample is also the last sum of the run
    add_item(OpTap, most_neg, 1'b1);
    add_item(OpSample, most_neg, 1'b0);
    add_item(OpSample, 16'sh7fff, 1'b1);
    // tap after a closed kernel restarts it; a sample against the open kernel is flagged
    add_item(OpTap, 16'sh7fff, 1'b0);
    add_item(OpSample, 16'sh0064, 1'b0);
    add_item(OpTap, most_neg, 1'b0);
    add_item(OpTap, 16'sh0001, 1'b1);
    // three-tap kernel with a flushed tail of two sums
    add_item(OpSample, most_neg, 1'b0);
    add_item(OpSample, 16'sh7fff, 1'b0);
    add_item(OpSample, 16'sh0000, 1'b0);
    add_item(OpSample, 16'shffff, 1'b1);
    // second signal on the same kernel, one sample long
    add_item(OpSample, 16'sh0005, 1'b1);
    // signal left open, then a new kernel clears its history
    add_item(OpSample, 16'sh7fff, 1'b0);
    add_item(OpTap, 16'sh0007, 1'b1);
    add_item(OpSample, most_neg, 1'b1);
    add_item(OpTap, 16'sh0000, 1'b0);
    add_item(OpTap, 16'shffff, 1'b1);
    add_item(OpSample, 16'sh7fff, 1'b1);
    add_item(OpSample, 16'sh5555, 1'b0);
    add_item(OpSample, 16'shaaaa, 1'b1);

    // largest products: an overfull kernel of the most negative tap against the same samples
    for (int i = 0; i < KernelTaps + 2; i++) add_item(OpTap, most_neg, i == KernelTaps + 1);
    for (int i = 0; i < 3; i++) add_item(OpSample, most_neg, i == 2);
    n_big++;

    // random part: mostly well-formed kernel then signal runs
    while (n_items < ItemGoal) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // samples against a kernel that is still open, then close it
        add_kernel($urandom_range(1, 3), 1'b0);
        add_signal($urandom_range(1, 2), $urandom_range(0, 1) != 0);
        add_item(OpTap, pick_value(), 1'b1);
      end else if (pick == 1 && n_big < 3) begin
        // near-full, full-size or overfull kernel, a few of these only since the flush is slow
        add_kernel($urandom_range(KernelTaps - 4, KernelTaps + 6), 1'b1);
        add_signal($urandom_range(1, 4), 1'b1);
        n_big++;
      end else if (pick == 2) begin
        // lone sample on whatever state the block is in
        add_item(OpSample, pick_value(), $urandom_range(0, 1) != 0);
      end else begin
        add_kernel(($urandom_range(0, 4) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4),
                   1'b1);
        // now and then a signal is left without its last sample
        repeat ($urandom_range(1, 3)) add_signal($urandom_range(1, 10), $urandom_range(0, 5) != 0);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // all items transferred and every predicted sum seen
    while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0) @(posedge clk);
    // quiet period to catch stray sums
    repeat (2 * KernelTaps + 16) @(posedge clk);

    $display("ran %0d taps and %0d samples, %0d sums checked, %0d flagged as having no kernel",
             n_taps, n_samples, n_results, n_no_kernel);
    $display("longest kernel held %0d taps, receiver held off for %0d cycles once",
             max_kernel, HoldCycles);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/flc_pkg.sv
design/flc_cell.sv
design/flc_chain.sv
design/full_linear_convolution_top.sv
dv/tb_full_linear_convolution_top.sv
